// ===== rtl/uer_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared constants, result codes and stage types of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned TIMEOUT_BITS = 16;
  localparam int unsigned CM_BITS = 11;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned DIST_BITS = 15;

  localparam int unsigned US_PER_CM = 58;
  localparam int unsigned CM58_BITS = CM_BITS + 6;
  localparam int unsigned TRIG_LOW_TICKS = 2;
  localparam int unsigned TRIG_HIGH_TICKS = 10;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] Q4_MAX = {DIST_BITS{1'b1}};

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(30000);
  localparam int unsigned MIN_CM_RESET = 2;
  localparam int unsigned MAX_CM_RESET = 400;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CM = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CM = 2'd2;

  // result status
  localparam logic [STATUS_BITS-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

  // w*16/58 = w*8/29, done as a multiply by a rounded-up reciprocal
  localparam int unsigned NUM_BITS = COUNT_BITS + 3;
  localparam int unsigned RECIP_SHIFT = COUNT_BITS + 8;
  localparam int unsigned RECIP_BITS = COUNT_BITS + 4;
  localparam longint unsigned RecipValue =
    ((64'd1 << RECIP_SHIFT) + 64'd28) / 64'd29;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(RecipValue);
  localparam int unsigned PROD_BITS = NUM_BITS + RECIP_BITS;
  localparam int unsigned QUOT_BITS = PROD_BITS - RECIP_SHIFT;

  localparam int unsigned WIDE_BITS = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;
  localparam int unsigned RANGE_BITS = (COUNT_BITS > CM58_BITS) ? COUNT_BITS : CM58_BITS;
  localparam int unsigned QCMP_BITS = (QUOT_BITS > DIST_BITS) ? QUOT_BITS : DIST_BITS;

  typedef struct packed {
    logic                  trig;
    logic                  busy;
    logic                  fin;
    logic                  timeout;
    logic [COUNT_BITS-1:0] width;
  } seq_out_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [DIST_BITS-1:0]   dist_q4;
  } dist_out_t;

endpackage
`default_nettype wire

// ===== rtl/uer_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_in_if
// Tick request channel: start request and sampled echo level.
// ----------------------------------------------------------------------------
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/uer_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_out_if
// Tick result channel: trigger level, busy, done, status and distance.
// ----------------------------------------------------------------------------
interface uer_out_if;
  import uer_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   trig_level;
  logic                   busy_res;
  logic                   done_res;
  logic [STATUS_BITS-1:0] status;
  logic [DIST_BITS-1:0]   distance_q4;

  modport source (
    output valid, output trig_level, output busy_res, output done_res,
    output status, output distance_q4, input ready
  );
  modport sink (
    input valid, input trig_level, input busy_res, input done_res,
    input status, input distance_q4, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/uer_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_seq
// Trigger and echo sequencer: phase state, wait counter and echo width.
// ----------------------------------------------------------------------------
module uer_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           start_i,
  input  wire logic                           echo_i,
  input  wire logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_i,
  output uer_pkg::seq_out_t                   seq_o
);
  import uer_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIG_LOW = 3'd1;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT_HIGH = 3'd3;
  localparam logic [2:0] PH_WAIT_LOW = 3'd4;

  logic [2:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] ticks_q, ticks_d;
  logic [COUNT_BITS-1:0] echo_q, echo_d;
  logic [COUNT_BITS-1:0] ticks_inc, echo_inc;
  logic                  trig, fin, timeout;

  assign ticks_inc = (ticks_q == CNT_MAX) ? ticks_q : ticks_q + COUNT_BITS'(1);
  assign echo_inc = (echo_q == CNT_MAX) ? echo_q : echo_q + COUNT_BITS'(1);

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    echo_d = echo_q;
    trig = 1'b0;
    fin = 1'b0;
    timeout = 1'b0;
    case (phase_q)
      PH_TRIG_LOW: begin
        ticks_d = ticks_inc;
        if (ticks_inc >= COUNT_BITS'(TRIG_LOW_TICKS)) begin
          phase_d = PH_TRIG_HIGH;
          ticks_d = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        ticks_d = ticks_inc;
        if (ticks_inc >= COUNT_BITS'(TRIG_HIGH_TICKS)) begin
          phase_d = PH_WAIT_HIGH;
          ticks_d = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (echo_i) begin
          phase_d = PH_WAIT_LOW;
          ticks_d = '0;
          echo_d = '0;
        end else if ((WIDE_BITS'(ticks_q) >= WIDE_BITS'(timeout_i)) ||
                     (ticks_q == CNT_MAX)) begin
          fin = 1'b1;
          timeout = 1'b1;
        end else begin
          ticks_d = ticks_inc;
        end
      end
      PH_WAIT_LOW: begin
        ticks_d = ticks_inc;
        echo_d = echo_inc;
        if (!echo_i) begin
          fin = 1'b1;
        end else if ((WIDE_BITS'(ticks_inc) >= WIDE_BITS'(timeout_i)) ||
                     (ticks_inc == CNT_MAX)) begin
          fin = 1'b1;
          timeout = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (start_i) begin
          phase_d = PH_TRIG_LOW;
          ticks_d = '0;
          echo_d = '0;
        end
      end
    endcase
    if (fin) begin
      phase_d = PH_IDLE;
      ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
      echo_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      echo_q <= echo_d;
    end
  end

  assign seq_o.trig = trig;
  assign seq_o.busy = (phase_d != PH_IDLE);
  assign seq_o.fin = fin;
  assign seq_o.timeout = timeout;
  assign seq_o.width = echo_d;

endmodule
`default_nettype wire

// ===== rtl/uer_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_dist
// Echo width to Q4 centimetres, range check and status.
// ----------------------------------------------------------------------------
module uer_dist (
  input  wire uer_pkg::seq_out_t              seq_i,
  input  wire logic [uer_pkg::CM58_BITS-1:0]  min58_i,
  input  wire logic [uer_pkg::CM58_BITS-1:0]  max58_i,
  output uer_pkg::dist_out_t                  res_o
);
  import uer_pkg::*;

  logic [PROD_BITS-1:0] prod;
  logic [QUOT_BITS-1:0] quot;
  logic                 out_of_range;
  logic                 sat;

  assign prod = PROD_BITS'({seq_i.width, 3'b000}) * PROD_BITS'(RECIP_MUL);
  assign quot = prod[PROD_BITS-1:RECIP_SHIFT];
  assign sat = QCMP_BITS'(quot) > QCMP_BITS'(Q4_MAX);
  assign out_of_range = (RANGE_BITS'(seq_i.width) < RANGE_BITS'(min58_i)) ||
                        (RANGE_BITS'(seq_i.width) > RANGE_BITS'(max58_i));

  always_comb begin
    res_o.status = ST_OK;
    res_o.dist_q4 = '0;
    if (seq_i.fin) begin
      if (seq_i.timeout) begin
        res_o.status = ST_TIMEOUT;
      end else if (out_of_range) begin
        res_o.status = ST_RANGE;
      end else begin
        res_o.dist_q4 = sat ? Q4_MAX : DIST_BITS'(QCMP_BITS'(quot));
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Trigger/echo range finder, one microsecond tick per request.
// ----------------------------------------------------------------------------
// Each request is one tick and yields exactly one result. A request is
// taken every cycle while the result register is free or being read; it is
// held in the input register, is worked through the sequencer and the
// width-to-distance multiply, and its result leaves from the result
// register, so throughput is one request per cycle unless results stall.
// Register writes are applied at once and belong to idle periods.
module ultrasonic_echo_ranger_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  uer_in_if.sink                                 in_ch_i,
  uer_out_if.source                              out_ch_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [uer_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import uer_pkg::*;

  logic                    in_valid_q;
  logic                    in_start_q, in_echo_q;
  logic                    advance;
  logic                    out_valid_q;
  logic                    out_trig_q, out_busy_q, out_done_q;
  logic [STATUS_BITS-1:0]  out_status_q;
  logic [DIST_BITS-1:0]    out_dist_q;
  logic [TIMEOUT_BITS-1:0] timeout_q;
  logic [CM58_BITS-1:0]    min58_q, max58_q;
  logic [CM58_BITS-1:0]    wr58;
  seq_out_t                seq;
  dist_out_t               res;

  assign advance = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !in_valid_q || advance;
  assign wr58 = CM58_BITS'(cfg_wdata_i[CM_BITS-1:0]) * CM58_BITS'(US_PER_CM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      min58_q <= CM58_BITS'(MIN_CM_RESET * US_PER_CM);
      max58_q <= CM58_BITS'(MAX_CM_RESET * US_PER_CM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMEOUT: timeout_q <= cfg_wdata_i[TIMEOUT_BITS-1:0];
        REG_MIN_CM: min58_q <= wr58;
        REG_MAX_CM: max58_q <= wr58;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      in_start_q <= in_ch_i.start_req;
      in_echo_q <= in_ch_i.echo_level;
    end
  end

  uer_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .start_i   (in_start_q),
    .echo_i    (in_echo_q),
    .timeout_i (timeout_q),
    .seq_o     (seq)
  );

  uer_dist u_dist (
    .seq_i   (seq),
    .min58_i (min58_q),
    .max58_i (max58_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_trig_q <= seq.trig;
      out_busy_q <= seq.busy;
      out_done_q <= seq.fin;
      out_status_q <= res.status;
      out_dist_q <= res.dist_q4;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.trig_level = out_trig_q;
  assign out_ch_o.busy_res = out_busy_q;
  assign out_ch_o.done_res = out_done_q;
  assign out_ch_o.status = out_status_q;
  assign out_ch_o.distance_q4 = out_dist_q;

endmodule
`default_nettype wire

// ===== verif/echo_ranger_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_ranger_checker
// Watches the tick and result channels of the echo ranger and the register
// port, runs its own model of the trigger/echo sequencer on every accepted
// tick request and compares each accepted result, field by field, with the
// oldest prediction. Hands the failure count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module echo_ranger_checker
  import uer_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  uer_in_if                        tick_ch,
  uer_out_if                       res_ch,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_HIGH = 3'd3,
    PH_WAIT_LOW  = 3'd4
  } ranger_phase_e;

  typedef struct packed {
    logic                   trig;
    logic                   busy;
    logic                   done;
    logic [STATUS_BITS-1:0] status;
    logic [DIST_BITS-1:0]   dist_q4;
  } tick_res_t;

  ranger_phase_e           ranger_phase;
  logic [COUNT_BITS-1:0]   phase_cnt;
  logic [COUNT_BITS-1:0]   echo_cnt;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  logic [CM_BITS-1:0]      min_cm;
  logic [CM_BITS-1:0]      max_cm;
  tick_res_t               expected_res_q[$];

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tick_res_t range_tick(input logic start, input logic echo);
    tick_res_t              r;
    logic                   finish;
    logic [STATUS_BITS-1:0] fin_status;
    int unsigned            width;
    int unsigned            quot;
    r = '0;
    finish = 1'b0;
    fin_status = ST_OK;
    case (ranger_phase)
      PH_TRIG_LOW: begin
        phase_cnt = bump(phase_cnt);
        if (phase_cnt >= TRIG_LOW_TICKS) begin
          ranger_phase = PH_TRIG_HIGH;
          phase_cnt = '0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trig = 1'b1;
        phase_cnt = bump(phase_cnt);
        if (phase_cnt >= TRIG_HIGH_TICKS) begin
          ranger_phase = PH_WAIT_HIGH;
          phase_cnt = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (echo) begin
          ranger_phase = PH_WAIT_LOW;
          phase_cnt = '0;
          echo_cnt = '0;
        end else if (phase_cnt >= timeout_ticks || phase_cnt == CNT_MAX) begin
          finish = 1'b1;
          fin_status = ST_TIMEOUT;
        end else begin
          phase_cnt = bump(phase_cnt);
        end
      end
      PH_WAIT_LOW: begin
        phase_cnt = bump(phase_cnt);
        echo_cnt = bump(echo_cnt);
        if (!echo) begin
          width = 32'(echo_cnt);
          finish = 1'b1;
          if (width < US_PER_CM * min_cm || width > US_PER_CM * max_cm) begin
            fin_status = ST_RANGE;
          end else begin
            quot = (width * 16) / US_PER_CM;
            r.dist_q4 = (quot > Q4_MAX) ? Q4_MAX : DIST_BITS'(quot);
          end
        end else if (phase_cnt >= timeout_ticks || phase_cnt == CNT_MAX) begin
          finish = 1'b1;
          fin_status = ST_TIMEOUT;
        end
      end
      default: begin
        ranger_phase = PH_IDLE;
        if (start) begin
          ranger_phase = PH_TRIG_LOW;
          phase_cnt = '0;
          echo_cnt = '0;
        end
      end
    endcase
    if (finish) begin
      ranger_phase = PH_IDLE;
      phase_cnt = '0;
      r.done = 1'b1;
      r.status = fin_status;
      if (fin_status != ST_OK) begin
        r.dist_q4 = '0;
      end
    end
    r.busy = (ranger_phase != PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) begin
      $display("%0t ns: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_res_t want;
    tick_res_t got;
    if (!rst_ni) begin
      ranger_phase = PH_IDLE;
      phase_cnt = '0;
      echo_cnt = '0;
      timeout_ticks = TIMEOUT_RESET;
      min_cm = CM_BITS'(MIN_CM_RESET);
      max_cm = CM_BITS'(MAX_CM_RESET);
      expected_res_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT: timeout_ticks = cfg_wdata_i[TIMEOUT_BITS-1:0];
          REG_MIN_CM:  min_cm = cfg_wdata_i[CM_BITS-1:0];
          REG_MAX_CM:  max_cm = cfg_wdata_i[CM_BITS-1:0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.trig_level, res_ch.busy_res, res_ch.done_res, res_ch.status,
                res_ch.distance_q4};
        if (expected_res_q.size() == 0) begin
          report_mismatch($sformatf("result %p with no request outstanding", got));
        end else begin
          want = expected_res_q.pop_front();
          if (got.trig !== want.trig)
            report_mismatch($sformatf("trig_level: expected %0d got %0d", want.trig, got.trig));
          if (got.busy !== want.busy)
            report_mismatch($sformatf("busy_res: expected %0d got %0d", want.busy, got.busy));
          if (got.done !== want.done)
            report_mismatch($sformatf("done_res: expected %0d got %0d", want.done, got.done));
          if (got.status !== want.status)
            report_mismatch($sformatf("status: expected %0d got %0d", want.status, got.status));
          if (got.dist_q4 !== want.dist_q4)
            report_mismatch($sformatf("distance_q4: expected %0d got %0d", want.dist_q4,
                                      got.dist_q4));
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        expected_res_q.push_back(range_tick(tick_ch.start_req, tick_ch.echo_level));
      end
      pending_o <= expected_res_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick requests into the echo ranger: a few directed measurements at
// the timing and range boundaries and the register extremes, then random
// phases of well-formed, broken and noisy sequences under bursty requests
// and a stalling receiver. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TRIG_TICKS = TRIG_LOW_TICKS + TRIG_HIGH_TICKS;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int unsigned              fail_count;
  int unsigned              pending;
  int unsigned              burst_left;
  int unsigned              cur_timeout;
  int unsigned              cur_min;
  int unsigned              cur_max;

  uer_in_if  tick_ch ();
  uer_out_if res_ch ();

  ultrasonic_echo_ranger_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch_i     (tick_ch),
    .out_ch_o    (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  echo_ranger_checker u_ranger_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_ch      (tick_ch),
    .res_ch       (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: changing stall modes, with a long hold-off now and then
  initial begin
    int unsigned rx_cycles;
    int unsigned rx_mode;
    int unsigned mode_left;
    rx_cycles = 0;
    rx_mode = 0;
    mode_left = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles % 40000 == 300) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_cycles += 400;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (rx_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= rx_cycles[0];
      endcase
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.start_req <= start;
    tick_ch.echo_level <= echo;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
  endtask

  // start request, trigger ticks, echo low for pre_ticks, high for high_ticks, low
  task automatic send_measurement(input int unsigned pre_ticks, input int unsigned high_ticks,
                                  input bit noisy);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (TRIG_TICKS) send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0,
                                  1'($urandom_range(0, 1)));
    repeat (pre_ticks) send_tick(1'b0, 1'b0);
    repeat (high_ticks) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic flush_ranger();
    repeat (TRIG_TICKS + cur_timeout + 2) send_tick(1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned timeout, input int unsigned min_cm,
                              input int unsigned max_cm);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_TIMEOUT;
    cfg_wdata <= CFG_DATA_BITS'(timeout);
    @(posedge clk_i);
    cfg_idx <= REG_MIN_CM;
    cfg_wdata <= CFG_DATA_BITS'(min_cm);
    @(posedge clk_i);
    cfg_idx <= REG_MAX_CM;
    cfg_wdata <= CFG_DATA_BITS'(max_cm);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_timeout = timeout;
    cur_min = min_cm;
    cur_max = max_cm;
  endtask

  initial begin
    int pre;
    int high;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_TIMEOUT;
    cfg_wdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.start_req <= 1'b0;
    tick_ch.echo_level <= 1'b0;
    burst_left = 0;
    cur_timeout = TIMEOUT_RESET;
    cur_min = MIN_CM_RESET;
    cur_max = MAX_CM_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: echo while idle, exact minimum width, one tick short
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_measurement(0, US_PER_CM * cur_min, 1'b1);
    send_measurement(3, US_PER_CM * cur_min - 1, 1'b1);

    // zero timeout: immediate rise passes, any wait fails
    apply_config(0, 0, 1130);
    send_measurement(0, 1, 1'b0);
    send_measurement(1, 5, 1'b0);
    send_measurement(0, 2, 1'b0);

    // minimum above maximum, with the shortest nonzero timeout
    apply_config(1, 1130, 0);
    send_measurement(1, 1, 1'b1);
    send_measurement(2, 1, 1'b0);

    for (int ph = 0; ph < 2; ph++) begin
      apply_config(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(58, 150),
                   $urandom_range(0, 2), $urandom_range(0, 2));
      for (int s = 0; s < 2; s++) begin
        case ($urandom_range(0, 9))
          0: begin
            send_tick(1'b1, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 30)) send_tick(1'($urandom_range(0, 1)),
                                                     1'($urandom_range(0, 1)));
            flush_ranger();
          end
          1: begin
            repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)),
                                                     1'($urandom_range(0, 1)));
            flush_ranger();
          end
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              pre = int'(cur_timeout) + int'($urandom_range(0, 2)) - 1;
            end else begin
              pre = $urandom_range(0, 4);
            end
            case ($urandom_range(0, 3))
              0: high = int'(US_PER_CM * cur_min) + int'($urandom_range(0, 1)) - 1;
              1: high = int'(US_PER_CM * cur_max) + int'($urandom_range(0, 1));
              2: high = int'(cur_timeout) + int'($urandom_range(0, 1));
              default: high = $urandom_range(1, 20);
            endcase
            if (pre < 0) pre = 0;
            if (high < 1) high = 1;
            if (high > int'(cur_timeout) + 2) high = int'(cur_timeout) + 2;
            send_measurement(pre, high, 1'($urandom_range(0, 1)));
          end
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
